// ===== rtl/matrix_vector_multiply_core_defines.svh =====
// Assertion macros shared by the matrix-vector multiply RTL.
// Depends on nothing; included by the top level only.
`ifndef MATRIX_VECTOR_MULTIPLY_CORE_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MVM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mvm assertion failed");

// Next-cycle implication, disabled while reset is high.
`define MVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mvm assertion failed");

`endif

// ===== rtl/mvm_pkg.sv =====
// Shared types, constants and helpers for the matrix-vector multiply core.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package mvm_pkg;

  localparam int MAX_N      = 1024;
  localparam int IDX_W      = 10;
  localparam int LEN_W      = 11;
  localparam int VAL_W      = 32;
  localparam int SUM_W      = 64;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 80;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_MATRIX = 1'b1
  } op_t;

  // Travels with a matrix word down the pipeline.
  typedef struct packed {
    logic             row_end;
    logic             last_row;
    logic [IDX_W-1:0] row_index;
  } tag_t;

  typedef struct packed {
    logic                    last_row;
    logic signed [SUM_W-1:0] row_sum;
    logic [IDX_W-1:0]        row_index;
  } result_t;

  // A length of zero acts as one, anything above MAX_N acts as MAX_N.
  function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = len;
    if (len == '0) begin
      n = LEN_W'(1);
    end else if (len > LEN_W'(MAX_N)) begin
      n = LEN_W'(MAX_N);
    end
    return n;
  endfunction

endpackage

// ===== rtl/mvm_mac.sv =====
// Multiply stage and saturating Q32.32 accumulator of the matrix-vector core.
// Depends on mvm_pkg.
`timescale 1ns / 1ps

module mvm_mac
  import mvm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [VAL_W-1:0] a,
  input  logic signed [VAL_W-1:0] b,
  input  tag_t                    in_tag,
  output logic                    pend_end,
  output logic                    push,
  output result_t                 res
);

  logic                    prod_valid;
  logic signed [SUM_W-1:0] prod;
  tag_t                    prod_tag;
  logic signed [SUM_W-1:0] acc;
  logic signed [SUM_W-1:0] raw_sum;
  logic signed [SUM_W-1:0] sat_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      prod     <= SUM_W'(a) * SUM_W'(b);
      prod_tag <= in_tag;
    end
  end

  // Overflow only when both operands share a sign that the sum lost.
  always_comb begin
    raw_sum = acc + prod;
    sat_sum = raw_sum;
    if (acc[SUM_W-1] == prod[SUM_W-1] && raw_sum[SUM_W-1] != acc[SUM_W-1]) begin
      sat_sum = acc[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= prod_tag.row_end ? '0 : sat_sum;
    end
  end

  assign pend_end      = prod_valid && prod_tag.row_end;
  assign push          = pend_end;
  assign res.row_index = prod_tag.row_index;
  assign res.row_sum   = sat_sum;
  assign res.last_row  = prod_tag.last_row;

endmodule

// ===== rtl/mvm_out_fifo.sv =====
// Small result queue that decouples the accumulator from the output stream.
// Depends on mvm_pkg.
`timescale 1ns / 1ps

module mvm_out_fifo
  import mvm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  result_t          push_word,
  input  logic             pop,
  output result_t          head,
  output logic             not_empty,
  output logic [CNT_W-1:0] count
);

  result_t          slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);

endmodule

// ===== rtl/matrix_vector_multiply_core.sv =====
// Top level of the matrix-vector multiply core: vector store, counters, flow control.
// Depends on mvm_pkg, mvm_mac, mvm_out_fifo and matrix_vector_multiply_core_defines.svh.
//
//   Channel   Direction  Word
//   s_axis    in         load of a vector element or one matrix element
//   m_axis    out        one row sum at the end of each matrix row
//   cfg       in         vector_length register write
//
// One input word is taken per cycle while s_axis_tready is high; a load causes no result.
// A row sum leaves after its final matrix word passes memory read,
// multiply register, then accumulation into the four-entry result queue.
// s_axis_tready drops when queued plus in-flight row ends would fill that queue.
// Reset clears counters, accumulator and queue; the vector store is not cleared.
`timescale 1ns / 1ps
`include "matrix_vector_multiply_core_defines.svh"

module matrix_vector_multiply_core
  import mvm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // vector_index[9:0], value[41:10]
  input  logic                  s_axis_tuser,  // opcode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // row_index[9:0], row_sum[73:10]
  output logic                  m_axis_tlast,  // last_row
  input  logic                  cfg_we,
  input  logic [LEN_W-1:0]      cfg_data       // vector_length
);

  logic [LEN_W-1:0]        vector_length;
  logic [LEN_W-1:0]        n_eff;
  logic [IDX_W-1:0]        column_count;
  logic [IDX_W-1:0]        row_count;
  logic                    in_acc;
  op_t                     op;
  logic [IDX_W-1:0]        vector_index;
  logic signed [VAL_W-1:0] value;
  logic                    is_mat;
  logic                    is_load;
  logic                    row_end;
  logic                    last_row;

  logic signed [VAL_W-1:0] vector_store [MAX_N];
  logic signed [VAL_W-1:0] rd_data;

  logic                    s1_valid;
  logic signed [VAL_W-1:0] s1_value;
  tag_t                    s1_tag;
  tag_t                    tag_next;

  logic                    pend_end;
  logic                    push;
  result_t                 res;
  result_t                 head;
  logic                    not_empty;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        committed;
  logic                    pop;

  assign in_acc       = s_axis_tvalid && s_axis_tready;
  assign op           = op_t'(s_axis_tuser);
  assign vector_index = s_axis_tdata[IDX_W-1:0];
  assign value        = s_axis_tdata[IDX_W+VAL_W-1:IDX_W];
  assign is_mat       = in_acc && (op == OP_MATRIX);
  assign is_load      = in_acc && (op == OP_LOAD);
  assign n_eff        = eff_length(vector_length);
  assign row_end      = ({1'b0, column_count} + LEN_W'(1)) >= n_eff;
  assign last_row     = ({1'b0, row_count} + LEN_W'(1)) >= n_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= LEN_W'(MAX_N);
    end else if (cfg_we) begin
      vector_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (is_mat) begin
      if (row_end) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + IDX_W'(1);
      end else begin
        column_count <= column_count + IDX_W'(1);
      end
    end
  end

  // Only one word enters per cycle, so a load and a read never meet on one edge.
  always_ff @(posedge clk) begin
    if (is_load && ({1'b0, vector_index} < n_eff)) begin
      vector_store[vector_index] <= value;
    end
    if (is_mat) begin
      rd_data <= vector_store[column_count];
    end
  end

  always_comb begin
    tag_next.row_end   = row_end;
    tag_next.last_row  = last_row;
    tag_next.row_index = row_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= is_mat;
    end
  end

  always_ff @(posedge clk) begin
    if (is_mat) begin
      s1_value <= value;
      s1_tag   <= tag_next;
    end
  end

  mvm_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_valid),
    .a        (s1_value),
    .b        (rd_data),
    .in_tag   (s1_tag),
    .pend_end (pend_end),
    .push     (push),
    .res      (res)
  );

  assign pop = m_axis_tvalid && m_axis_tready;

  mvm_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (res),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .count     (count)
  );

  // Every row end already in the pipeline has a queue slot reserved.
  assign committed = count + CNT_W'(s1_valid && s1_tag.row_end) + CNT_W'(pend_end);
  assign s_axis_tready = committed < CNT_W'(FIFO_DEPTH);

  assign m_axis_tvalid = not_empty;
  assign m_axis_tdata  = {{(OUT_DATA_W-IDX_W-SUM_W){1'b0}}, head.row_sum, head.row_index};
  assign m_axis_tlast  = head.last_row;

  `MVM_ASSERT_NOW(a_no_overflow, clk, rst, push && !pop, count != CNT_W'(FIFO_DEPTH))
  `MVM_ASSERT_NEXT(a_col_clear, clk, rst, is_mat && row_end, column_count == '0)
  `MVM_ASSERT_NEXT(a_col_step, clk, rst, is_mat && !row_end,
                   column_count == $past(column_count) + IDX_W'(1))

endmodule
